@@ src/abs_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// abs_pkg: shared types and constants for the background subtractor
// Register indexes, store geometry and the beat carried between front and back.
// ---------------------------------------------------------------------------
package abs_pkg;
    localparam int NUM_PIXELS = 2097152;
    localparam int AW = $clog2(NUM_PIXELS);
    localparam int ADDR_W = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ENTRY_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSTILL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RMOVE  = 3'd4;

    localparam logic [16:0] RATE_ONE = 17'd65536;
    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        val;
        logic [7:0]        sat;
        logic              init;
        logic              in_range;
    } t_item;

    typedef struct packed {
        logic [23:0] noise;
        logic [15:0] spread;
        logic [7:0]  bright;
        logic [16:0] rstill;
        logic [16:0] rmove;
    } t_cfg;
endpackage
`default_nettype wire

@@ src/abs_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// abs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module abs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ src/abs_fifo.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// abs_fifo: short queue between front and back
// Four-entry register queue that lets the front and the back stall apart.
// ---------------------------------------------------------------------------
module abs_fifo
    import abs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_data
);
    t_item      r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, i_pop};
        end
    end
endmodule
`default_nettype wire

@@ src/abs_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// abs_back: background model pipeline
// Reads the pixel state, classifies, blends and writes back, in pipeline
// stages. A beat for a pixel still in flight waits until it has been written.
// ---------------------------------------------------------------------------
module abs_back
    import abs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    input  wire t_item             i_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [ADDR_W-1:0] o_pixel_addr_out,
    output logic                   o_foreground,
    output logic                   o_value_changed,
    output logic                   o_sat_changed
);
    // Stages: s1 RAM read, s2 deviation and products, s3 compare and select,
    // s4 blend products, s5 sum/saturate and write, then output register.
    logic  r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item r_i1, r_i2, r_i3, r_i4, r_i5;
    logic  adv;
    logic [ENTRY_W-1:0] ram_q, wdata;
    logic               ram_we;
    logic               hazard;

    // Pipeline moves whenever the output slot is free or being taken.
    logic r_ov;
    assign adv   = !r_ov || !i_stall;
    assign o_valid = r_ov;

    // The store is read before any earlier beat of the same pixel has written
    // it, so such a beat stays in the queue until the pixel has left stage 5.
    assign hazard = i_valid && ((r_v1 && r_i1.addr == i_item.addr)
                             || (r_v2 && r_i2.addr == i_item.addr)
                             || (r_v3 && r_i3.addr == i_item.addr)
                             || (r_v4 && r_i4.addr == i_item.addr)
                             || (r_v5 && r_i5.addr == i_item.addr));
    assign o_pop = adv && i_valid && !hazard;

    abs_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PIXELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_i5.addr[AW-1:0]),
        .i_wdata(wdata),
        .i_re   (adv),
        .i_raddr(i_item.addr[AW-1:0]),
        .o_rdata(ram_q)
    );

    // Entry layout: mean_value, mean_sat, spread_value, spread_sat.
    logic [23:0] mv, ms, sv, ss;
    assign {mv, ms, sv, ss} = ram_q;

    logic [23:0] dv, ds;
    assign dv = ({r_i1.val, 16'd0} >= mv) ? {r_i1.val, 16'd0} - mv
                                           : mv - {r_i1.val, 16'd0};
    assign ds = ({r_i1.sat, 16'd0} >= ms) ? {r_i1.sat, 16'd0} - ms
                                           : ms - {r_i1.sat, 16'd0};

    logic [47:0] r_dv2, r_ds2;
    logic [39:0] r_tv, r_ts;
    logic [23:0] r_mv2, r_ms2, r_sv2, r_ss2;
    logic        r_vch, r_sch, r_fg;
    logic [47:0] r_dv3, r_ds3;
    logic [23:0] r_mv3, r_ms3, r_sv3, r_ss3;
    logic [40:0] r_pmv, r_pms, r_psv, r_pss;
    logic [64:0] r_qv, r_qs;
    logic [24:0] r_xv, r_xs;
    logic        r_fg4, r_vch4, r_sch4, r_fg5, r_vch5, r_sch5;
    logic [23:0] r_mv5, r_ms5, r_sv5, r_ss5;
    logic [23:0] n_mv, n_ms, n_sv, n_ss;

    function automatic logic [23:0] sat24(input logic [65:0] v);
        return (v > {42'd0, MAX24}) ? MAX24 : v[23:0];
    endfunction

    // Thresholds carry one bit of headroom over k^2 * variance plus the floor.
    logic [40:0] thr_v, thr_s;
    logic [42:0] thr3_s;
    logic        vch, sch;
    assign thr_v  = {1'b0, r_tv} + {9'd0, i_cfg.noise, 8'd0};
    assign thr_s  = {1'b0, r_ts} + {9'd0, i_cfg.noise, 8'd0};
    assign thr3_s = {1'b0, thr_s, 1'b0} + {2'd0, thr_s};
    assign vch    = {9'd0, r_dv2} > {thr_v, 16'd0};
    assign sch    = {10'd0, r_ds2, 1'b0} > {thr3_s, 16'd0};

    logic [16:0] rate_raw, rate, ia;
    assign rate_raw = r_fg ? i_cfg.rmove : i_cfg.rstill;
    assign rate     = (rate_raw > RATE_ONE) ? RATE_ONE : rate_raw;
    assign ia       = RATE_ONE - rate;

    assign n_sv = sat24({41'd0, r_psv[40:16]} + {41'd0, r_qv[64:40]});
    assign n_ss = sat24({41'd0, r_pss[40:16]} + {41'd0, r_qs[64:40]});
    assign n_mv = sat24({41'd0, r_pmv[40:16]} + {41'd0, r_xv});
    assign n_ms = sat24({41'd0, r_pms[40:16]} + {41'd0, r_xs});

    assign wdata = r_i5.init ? {r_i5.val, 16'd0, r_i5.sat, 16'd0, i_cfg.noise, i_cfg.noise}
                             : {r_mv5, r_ms5, r_sv5, r_ss5};
    assign ram_we = adv && r_v5 && r_i5.in_range;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i1 <= i_item;
            r_i2 <= r_i1; r_i3 <= r_i2; r_i4 <= r_i3; r_i5 <= r_i4;
            // stage 2
            r_dv2 <= {24'd0, dv} * {24'd0, dv};
            r_ds2 <= {24'd0, ds} * {24'd0, ds};
            r_tv  <= {16'd0, sv} * {24'd0, i_cfg.spread};
            r_ts  <= {16'd0, ss} * {24'd0, i_cfg.spread};
            r_mv2 <= mv; r_ms2 <= ms; r_sv2 <= sv; r_ss2 <= ss;
            // stage 3
            r_dv3 <= r_dv2; r_ds3 <= r_ds2;
            r_mv3 <= r_mv2; r_ms3 <= r_ms2; r_sv3 <= r_sv2; r_ss3 <= r_ss2;
            r_fg  <= (vch || sch) && r_i2.val > i_cfg.bright;
            r_vch <= vch;
            r_sch <= sch;
            // stage 4
            r_pmv <= {17'd0, r_mv3} * {24'd0, ia};
            r_pms <= {17'd0, r_ms3} * {24'd0, ia};
            r_psv <= {17'd0, r_sv3} * {24'd0, ia};
            r_pss <= {17'd0, r_ss3} * {24'd0, ia};
            r_qv  <= {17'd0, r_dv3} * {48'd0, rate};
            r_qs  <= {17'd0, r_ds3} * {48'd0, rate};
            r_xv  <= {17'd0, r_i3.val} * {8'd0, rate};
            r_xs  <= {17'd0, r_i3.sat} * {8'd0, rate};
            r_fg4 <= r_fg; r_vch4 <= r_vch; r_sch4 <= r_sch;
            // stage 5
            r_mv5 <= n_mv; r_ms5 <= n_ms; r_sv5 <= n_sv; r_ss5 <= n_ss;
            r_fg5 <= r_fg4; r_vch5 <= r_vch4; r_sch5 <= r_sch4;
        end
        if (adv && r_v5) begin
            o_pixel_addr_out <= r_i5.addr;
            o_foreground     <= !r_i5.init && r_fg5;
            o_value_changed  <= !r_i5.init && r_vch5;
            o_sat_changed    <= !r_i5.init && r_sch5;
        end
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_ov} <= '0;
        end else begin
            if (adv) begin
                r_v1 <= i_valid && !hazard;
                r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
                r_ov <= r_v5;
            end
        end
    end
endmodule
`default_nettype wire

@@ src/adaptive_background_subtractor.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// adaptive_background_subtractor: per-pixel running Gaussian background model
// Front accepts and tags pixels, a queue decouples it from the model pipeline.
// ---------------------------------------------------------------------------
// Input beats carry a pixel address, its value and saturation bytes and an
// init flag; each beat gives exactly one output beat with the address echoed
// and the foreground and per-channel change flags. An init beat loads the
// background for that pixel and reports all flags low.
// Throughput is one pixel per clock while no beat names a pixel still in the
// model stages and the receiver does not stall. An accepted beat passes
// through the queue, then five model stages (store read, squaring, compare,
// blend products, sums and write) and the output register.
// A beat whose pixel is still in the model stages waits in the queue until
// that earlier beat has written the store, so a pixel repeated back to back
// holds up the beats queued behind it.
// A stalled valid output beat holds, and the whole pipeline freezes; the
// queue then fills and the input stall rises once four beats wait in it.
// Reset clears control state and loads register defaults; the pixel store
// is not cleared and must be written by an init frame before use.
// The user must write configuration only while the block is idle; the block itself does not enforce this.
module adaptive_background_subtractor
    import abs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [ADDR_W-1:0]     i_pixel_addr,
    input  wire logic [7:0]            i_val,
    input  wire logic [7:0]            i_sat,
    input  wire logic                  i_init_frame,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [ADDR_W-1:0]     o_pixel_addr_out,
    output logic                       o_foreground,
    output logic                       o_value_changed,
    output logic                       o_sat_changed
);
    t_cfg  r_cfg;
    t_item item, q_item;
    logic  full, q_valid, pop, push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{noise: 24'd30976, spread: 16'd2304, bright: 8'd40,
                       rstill: 17'd1311, rmove: 17'd983};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NOISE:  r_cfg.noise  <= i_cfg_data;
                REG_SPREAD: r_cfg.spread <= i_cfg_data[15:0];
                REG_BRIGHT: r_cfg.bright <= i_cfg_data[7:0];
                REG_RSTILL: r_cfg.rstill <= i_cfg_data[16:0];
                REG_RMOVE:  r_cfg.rmove  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Front: tag beats whose address lies outside the store.
    assign item = '{addr: i_pixel_addr, val: i_val, sat: i_sat, init: i_init_frame,
                    in_range: ({3'd0, i_pixel_addr} < 24'(NUM_PIXELS))};
    assign o_stall = full;
    assign push = i_valid && !full;

    abs_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(item),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_data(q_item)
    );

    abs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(q_valid), .i_item(q_item), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_addr_out(o_pixel_addr_out), .o_foreground(o_foreground),
        .o_value_changed(o_value_changed), .o_sat_changed(o_sat_changed)
    );

`ifndef SYNTHESIS
    a_fg_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_foreground |-> o_value_changed || o_sat_changed)
        else $error("foreground without a changed channel");
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_addr_out))
        else $error("stalled output beat changed");
`endif
endmodule
`default_nettype wire
